@@ sv/usbmidi_pkg.sv @@
// Package for the USB-MIDI event depacketizer: item structs, code index
// constants and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package usbmidi_pkg;

    // Code index numbers that steer SysEx handling
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

    localparam logic [7:0] HEADER_NULL = 8'h00;

    // Result kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    localparam logic [2:0] BYTES_FULL = 3'd4;

    typedef struct packed {
        logic [3:0] cable_number;
        logic [3:0] code_index;
        logic [7:0] data_byte_one;
        logic [7:0] data_byte_two;
        logic [7:0] data_byte_three;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte_zero;
        logic [7:0] out_byte_one;
        logic [7:0] out_byte_two;
        logic [7:0] out_byte_three;
        logic [2:0] valid_bytes;
        logic       chunk_last;
        logic       sysex_overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_CAPTURE,
        ST_EMIT
    } t_state;

endpackage

@@ sv/usbmidi_byte_store.sv @@
// SysEx byte store: byte memory with a write port and a separate registered
// read port, one write and one read per cycle. No package dependencies.
`timescale 1ns / 1ps

module usbmidi_byte_store #(
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write one byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/usb_midi_event_depacketizer_unit.sv @@
// Top level of the USB-MIDI event depacketizer: sequencer, SysEx store
// and output register. Uses usbmidi_pkg and usbmidi_byte_store.
`timescale 1ns / 1ps

// Input channel: one 4-byte USB-MIDI event packet per item (i_in_valid /
// o_in_stall). Output channel: passed-through packets and SysEx chunks
// (o_out_valid / i_out_stall), each held in an output register.
// A packet is taken only while the sequencer is idle; one item is in work
// at a time. A null header or a SysEx end with no message open is taken
// and gives no result. A SysEx start/continue packet is accepted, then its
// three bytes are written to the store, one byte per cycle on the single
// memory write port. A pass-through packet moves from idle to the emit
// state and is loaded into the output register there once it is free.
// A SysEx end is accepted and its one to three bytes are written, then
// each stored byte is read and captured on the memory read port, and each
// chunk of up to 4 bytes is loaded into the output register in the emit state.
// When the receiver stalls, the result stays in the output register and
// the sequencer waits to load the next one.
// Reset clears the sequencer, the open flag, the fill count, the overflow
// flag and the output valid; the store itself is not cleared, since only
// bytes written during the current message are ever read.
module usb_midi_event_depacketizer_unit #(
    parameter int SYSEX_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  usbmidi_pkg::t_in_item i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output usbmidi_pkg::t_out_item o_out_item
);

    localparam int FILL_W = $clog2(SYSEX_DEPTH + 1);
    localparam int ADDR_W = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SYSEX_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    usbmidi_pkg::t_state r_state, n_state;

    logic              r_open;
    logic [FILL_W-1:0] r_fill;
    logic              r_ovf;
    logic [7:0]        r_bytes [3];
    logic [1:0]        r_widx;
    logic [1:0]        r_wlast;
    logic              r_end;
    logic [FILL_W-1:0] r_rd_ptr;
    logic [1:0]        r_lane;
    logic [7:0]        r_chunk [4];
    logic              r_kind;
    logic [2:0]        r_vb;
    logic              r_last;
    logic              r_out_valid;
    usbmidi_pkg::t_out_item r_out_item;

    logic       in_acc;
    logic [7:0] header;
    logic       is_null;
    logic       is_cont;
    logic       is_end;
    logic       store_we;
    logic       out_free;
    logic       out_load;
    logic       store_space;
    logic       wr_done;
    logic       chunk_done;
    logic       ptr_at_end;
    logic [7:0] rd_data;

    // Decode the incoming header
    assign header  = {i_in_item.cable_number, i_in_item.code_index};
    assign is_null = (header == usbmidi_pkg::HEADER_NULL);
    assign is_cont = (i_in_item.code_index == usbmidi_pkg::CIN_SYSEX_CONT);
    assign is_end  = (i_in_item.code_index == usbmidi_pkg::CIN_SYSEX_END1)
                  || (i_in_item.code_index == usbmidi_pkg::CIN_SYSEX_END2)
                  || (i_in_item.code_index == usbmidi_pkg::CIN_SYSEX_END3);

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign store_space = (r_fill < FILL_MAX);
    assign wr_done     = (r_widx == r_wlast);
    assign ptr_at_end  = ((r_rd_ptr + FILL_ONE) == r_fill);
    assign chunk_done  = (r_lane == 2'd3) || ptr_at_end;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            usbmidi_pkg::ST_IDLE: begin
                if (i_in_valid && !is_null) begin
                    if (is_cont || (is_end && r_open)) begin
                        n_state = usbmidi_pkg::ST_WRITE;
                    end else if (!is_end) begin
                        n_state = usbmidi_pkg::ST_EMIT;
                    end
                end
            end
            usbmidi_pkg::ST_WRITE: begin
                if (wr_done) begin
                    n_state = r_end ? usbmidi_pkg::ST_READ : usbmidi_pkg::ST_IDLE;
                end
            end
            usbmidi_pkg::ST_READ: begin
                n_state = usbmidi_pkg::ST_CAPTURE;
            end
            usbmidi_pkg::ST_CAPTURE: begin
                n_state = chunk_done ? usbmidi_pkg::ST_EMIT : usbmidi_pkg::ST_READ;
            end
            usbmidi_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = r_last ? usbmidi_pkg::ST_IDLE : usbmidi_pkg::ST_READ;
                end
            end
            default: begin
                n_state = usbmidi_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        store_we   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            usbmidi_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            usbmidi_pkg::ST_WRITE: begin
                store_we = store_space;
            end
            usbmidi_pkg::ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usbmidi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Message state: open flag, fill count, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (in_acc && !is_null) begin
                if (is_cont) begin
                    if (!r_open) begin
                        r_fill <= '0;
                        r_ovf  <= 1'b0;
                    end
                    r_open <= 1'b1;
                end else if (!is_end) begin
                    // abort any open message
                    r_open <= 1'b0;
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                end
            end else if (r_state == usbmidi_pkg::ST_WRITE) begin
                if (store_space) begin
                    r_fill <= r_fill + FILL_ONE;
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (out_load && r_last) begin
                r_open <= 1'b0;
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    // Capture packet bytes and walk them into the store
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bytes[0] <= i_in_item.data_byte_one;
            r_bytes[1] <= i_in_item.data_byte_two;
            r_bytes[2] <= i_in_item.data_byte_three;
            r_widx     <= 2'd0;
            r_end      <= is_end;
            r_wlast    <= is_end ? (i_in_item.code_index[1:0] - 2'd1) : 2'd2;
        end else if (r_state == usbmidi_pkg::ST_WRITE) begin
            r_widx <= r_widx + 2'd1;
        end
    end

    // Assemble chunks from store reads, or hold a pass-through packet
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_ptr   <= '0;
            r_lane     <= 2'd0;
            r_kind     <= is_end ? usbmidi_pkg::KIND_SYSEX : usbmidi_pkg::KIND_EVENT;
            r_vb       <= usbmidi_pkg::BYTES_FULL;
            r_last     <= 1'b1;
            r_chunk[0] <= is_end ? 8'h00 : header;
            r_chunk[1] <= is_end ? 8'h00 : i_in_item.data_byte_one;
            r_chunk[2] <= is_end ? 8'h00 : i_in_item.data_byte_two;
            r_chunk[3] <= is_end ? 8'h00 : i_in_item.data_byte_three;
        end else if (r_state == usbmidi_pkg::ST_CAPTURE) begin
            r_chunk[r_lane] <= rd_data;
            r_rd_ptr        <= r_rd_ptr + FILL_ONE;
            r_lane          <= r_lane + 2'd1;
            r_vb            <= {1'b0, r_lane} + 3'd1;
            r_last          <= ptr_at_end;
        end else if (out_load) begin
            r_lane     <= 2'd0;
            r_chunk[0] <= 8'h00;
            r_chunk[1] <= 8'h00;
            r_chunk[2] <= 8'h00;
            r_chunk[3] <= 8'h00;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.out_kind       <= r_kind;
            r_out_item.out_byte_zero  <= r_chunk[0];
            r_out_item.out_byte_one   <= r_chunk[1];
            r_out_item.out_byte_two   <= r_chunk[2];
            r_out_item.out_byte_three <= r_chunk[3];
            r_out_item.valid_bytes    <= r_vb;
            r_out_item.chunk_last     <= r_last;
            r_out_item.sysex_overflow <= (r_kind == usbmidi_pkg::KIND_SYSEX) && r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    usbmidi_byte_store #(
        .DEPTH  (SYSEX_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_bytes[r_widx]),
        .i_raddr (r_rd_ptr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

endmodule

@@ sv/usbmidi_checker.sv @@
// Port-level checks for the USB-MIDI event depacketizer, bound to the top
// level. Uses usbmidi_pkg.
`timescale 1ns / 1ps

module usbmidi_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input usbmidi_pkg::t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed or dropped");

    // Keep the byte count in range
    a_vb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.valid_bytes != 3'd0)
                     && (o_out_item.valid_bytes <= usbmidi_pkg::BYTES_FULL))
        else $error("valid_bytes out of range");

    // Pass-through packets are whole, final and never flagged
    a_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.out_kind == usbmidi_pkg::KIND_EVENT)
        |-> o_out_item.chunk_last && !o_out_item.sysex_overflow
         && (o_out_item.valid_bytes == usbmidi_pkg::BYTES_FULL))
        else $error("malformed pass-through item");

    // Only the final SysEx chunk may be short
    a_chunk_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.out_kind == usbmidi_pkg::KIND_SYSEX)
        && !o_out_item.chunk_last
        |-> (o_out_item.valid_bytes == usbmidi_pkg::BYTES_FULL))
        else $error("short SysEx chunk before the last");

endmodule

bind usb_midi_event_depacketizer_unit usbmidi_checker u_usbmidi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
